@@ rtl/fdsa_pkg.sv @@
// shared constants, codes and memory request types for the sector allocator
package fdsa_pkg;

    localparam int NUM_SECTORS      = 256;
    localparam int DIR_ENTRIES      = 16;
    localparam int SLOTS_PER_FILE   = 26;
    localparam int NAME_BYTES       = 6;
    localparam int RESERVED_SECTORS = 3;

    localparam int NAME_W  = 48;
    localparam int SLOT_W  = 8;
    localparam int SECT_W  = $clog2(NUM_SECTORS);
    localparam int ENT_W   = $clog2(DIR_ENTRIES);
    localparam int SLOT_CW = $clog2(SLOTS_PER_FILE + 1);
    localparam int FREE_W  = $clog2(NUM_SECTORS + 1);
    localparam int ADDR_W  = $clog2(DIR_ENTRIES * SLOTS_PER_FILE);

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_WRITE  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_ENTRY  = 2'd2;
    localparam logic [1:0] ST_DISK_FULL = 2'd3;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] wdata;
    } slot_req_t;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [SECT_W-1:0] addr;
        logic              wdata;
    } bm_req_t;

endpackage

@@ rtl/fdsa_bitmap.sv @@
// sector-use bitmap memory, one bit per sector, registered read
module fdsa_bitmap
(
    input  logic             clk,
    input  fdsa_pkg::bm_req_t req,
    output logic             rdata
);
    import fdsa_pkg::*;

    logic mem [NUM_SECTORS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

@@ rtl/fdsa_slot_mem.sv @@
// directory slot memory, one sector number per slot, registered read
module fdsa_slot_mem
(
    input  logic                          clk,
    input  fdsa_pkg::slot_req_t           req,
    output logic [fdsa_pkg::SLOT_W-1:0]   rdata
);
    import fdsa_pkg::*;

    logic [SLOT_W-1:0] mem [DIR_ENTRIES * SLOTS_PER_FILE];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

@@ rtl/flat_directory_sector_allocator.sv @@
// flat directory sector allocator: request sequencer, names and free count
//
// channel  signals                                   direction
// in       in_valid/in_stall, req_type, file_name,   request words in
//          sector_count
// out      out_valid/out_stall, status, entry_index, result words out
//          sector_valid, slot_index, sector_number, last
//
// one request at a time; lookup scans names one per cycle (up to 16)
// read: lookup, then a count of the used slots, then one word per sector listed
// write: lookup, delete (read, check, bitmap clear per slot), empty scan,
// then a walk of the bitmap for free sectors and 26 slot writes
// after reset one pass initializes all 256 bitmap bits, no request taken
// out_stall holds the sequencer whenever a result word cannot be placed
module flat_directory_sector_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [fdsa_pkg::NAME_W-1:0]   file_name,
    input  logic [5:0]                    sector_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [3:0]                    entry_index,
    output logic                          sector_valid,
    output logic [4:0]                    slot_index,
    output logic [7:0]                    sector_number,
    output logic                          last
);
    import fdsa_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_CNT_RD, S_CNT_CHK, S_EM_RD, S_EM_OUT,
        S_FR_RD, S_FR_CHK, S_FR_BM, S_EMPTY, S_AL_RD, S_AL_CHK, S_ZERO, S_ONE
    } state_t;

    state_t               state_reg;
    logic [SECT_W-1:0]    clr_reg;
    logic [1:0]           req_reg;
    logic [NAME_W-1:0]    name_reg;
    logic [SLOT_CW-1:0]   cnt_reg;
    logic [SLOT_CW-1:0]   cnt_n_reg;
    logic [SLOT_CW-1:0]   idx_reg;
    logic [ENT_W-1:0]     ent_reg;
    logic [SECT_W-1:0]    sec_reg;
    logic [FREE_W-1:0]    free_reg;
    logic [NAME_W-1:0]    names_reg [DIR_ENTRIES];
    logic [1:0]           pend_status_reg;
    logic [ENT_W-1:0]     pend_ent_reg;

    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [3:0]           entry_reg;
    logic                 sv_reg;
    logic [4:0]           slot_reg;
    logic [7:0]           sector_reg;
    logic                 last_reg;

    logic [NAME_W-1:0]    name_norm;
    logic                 name_stop;
    logic [SLOT_CW-1:0]   cnt_sat;
    logic                 out_free;
    logic                 out_load;
    logic                 slot_in_range;
    logic [ADDR_W-1:0]    slot_addr;
    slot_req_t            slot_req;
    bm_req_t              bm_req;
    logic [SLOT_W-1:0]    slot_rdata;
    logic                 bm_rdata;

    // name is cut at its first zero byte
    always_comb
    begin
        name_stop = 1'b0;
        name_norm = '0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (file_name[8*b +: 8] == 8'd0)
            begin
                name_stop = 1'b1;
            end
            if (!name_stop)
            begin
                name_norm[8*b +: 8] = file_name[8*b +: 8];
            end
        end
    end

    assign cnt_sat = (7'(sector_count) > 7'(SLOTS_PER_FILE)) ?
                     SLOT_CW'(SLOTS_PER_FILE) : SLOT_CW'(sector_count);

    assign out_free      = !out_valid_reg || !out_stall;
    assign slot_addr     = ADDR_W'(ent_reg) * ADDR_W'(SLOTS_PER_FILE) + ADDR_W'(idx_reg);
    assign slot_in_range = (10'(slot_rdata) < 10'(NUM_SECTORS));

    // a result word is placed this cycle
    assign out_load = out_free && ((state_reg == S_EM_OUT) || (state_reg == S_ONE) ||
                                   (state_reg == S_AL_CHK && !bm_rdata));

    always_comb
    begin
        slot_req       = '0;
        slot_req.addr  = slot_addr;
        bm_req         = '0;
        bm_req.addr    = sec_reg;
        unique case (state_reg)
            S_CLR:
            begin
                bm_req.we    = 1'b1;
                bm_req.addr  = clr_reg;
                bm_req.wdata = (9'(clr_reg) < 9'(RESERVED_SECTORS));
            end
            S_CNT_RD, S_EM_RD, S_FR_RD:
            begin
                slot_req.re = (idx_reg != SLOT_CW'(SLOTS_PER_FILE));
            end
            S_FR_CHK:
            begin
                bm_req.re   = (slot_rdata != '0) && slot_in_range;
                bm_req.addr = slot_rdata[SECT_W-1:0];
            end
            S_FR_BM:
            begin
                bm_req.we    = bm_rdata;
                bm_req.wdata = 1'b0;
            end
            S_AL_RD:
            begin
                bm_req.re = 1'b1;
            end
            S_AL_CHK:
            begin
                bm_req.we      = !bm_rdata && out_free;
                bm_req.wdata   = 1'b1;
                slot_req.we    = !bm_rdata && out_free;
                slot_req.wdata = SLOT_W'(sec_reg);
            end
            S_ZERO:
            begin
                slot_req.we = (idx_reg != SLOT_CW'(SLOTS_PER_FILE));
            end
            default:
            begin
            end
        endcase
    end

    fdsa_slot_mem u_slot_mem
    (
        .clk   (clk),
        .req   (slot_req),
        .rdata (slot_rdata)
    );

    fdsa_bitmap u_bitmap
    (
        .clk   (clk),
        .req   (bm_req),
        .rdata (bm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            clr_reg         <= '0;
            req_reg         <= REQ_READ;
            name_reg        <= '0;
            cnt_reg         <= '0;
            cnt_n_reg       <= '0;
            idx_reg         <= '0;
            ent_reg         <= '0;
            sec_reg         <= '0;
            free_reg        <= FREE_W'(NUM_SECTORS - RESERVED_SECTORS);
            for (int e = 0; e < DIR_ENTRIES; e++)
            begin
                names_reg[e] <= '0;
            end
            pend_status_reg <= ST_OK;
            pend_ent_reg    <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            entry_reg       <= '0;
            sv_reg          <= 1'b0;
            slot_reg        <= '0;
            sector_reg      <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SECT_W'(NUM_SECTORS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && req_type != 2'd3)
                    begin
                        req_reg  <= req_type;
                        name_reg <= name_norm;
                        cnt_reg  <= cnt_sat;
                        ent_reg  <= '0;
                        if (name_norm[7:0] == 8'd0)
                        begin
                            pend_status_reg <= ST_NOT_FOUND;
                            pend_ent_reg    <= '0;
                            state_reg       <= S_ONE;
                        end
                        else
                        begin
                            state_reg <= S_LOOK;
                        end
                    end
                end
                S_LOOK:
                begin
                    if (names_reg[ent_reg][7:0] != 8'd0 && names_reg[ent_reg] == name_reg)
                    begin
                        idx_reg   <= '0;
                        cnt_n_reg <= '0;
                        state_reg <= (req_reg == REQ_READ) ? S_CNT_RD : S_FR_RD;
                    end
                    else if (ent_reg == ENT_W'(DIR_ENTRIES - 1))
                    begin
                        if (req_reg == REQ_WRITE)
                        begin
                            ent_reg   <= '0;
                            state_reg <= S_EMPTY;
                        end
                        else
                        begin
                            pend_status_reg <= ST_NOT_FOUND;
                            pend_ent_reg    <= '0;
                            state_reg       <= S_ONE;
                        end
                    end
                    else
                    begin
                        ent_reg <= ent_reg + 1'b1;
                    end
                end
                S_CNT_RD:
                begin
                    if (idx_reg == SLOT_CW'(SLOTS_PER_FILE))
                    begin
                        idx_reg <= '0;
                        if (cnt_n_reg == '0)
                        begin
                            pend_status_reg <= ST_OK;
                            pend_ent_reg    <= ent_reg;
                            state_reg       <= S_ONE;
                        end
                        else
                        begin
                            state_reg <= S_EM_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CNT_CHK;
                    end
                end
                S_CNT_CHK:
                begin
                    if (slot_rdata == '0)
                    begin
                        idx_reg <= '0;
                        if (cnt_n_reg == '0)
                        begin
                            pend_status_reg <= ST_OK;
                            pend_ent_reg    <= ent_reg;
                            state_reg       <= S_ONE;
                        end
                        else
                        begin
                            state_reg <= S_EM_RD;
                        end
                    end
                    else
                    begin
                        cnt_n_reg <= cnt_n_reg + 1'b1;
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_OUT;
                end
                S_EM_OUT:
                begin
                    if (out_free)
                    begin
                        status_reg    <= ST_OK;
                        entry_reg     <= 4'(ent_reg);
                        sv_reg        <= 1'b1;
                        slot_reg      <= 5'(idx_reg);
                        sector_reg    <= 8'(slot_rdata);
                        last_reg      <= (idx_reg == cnt_n_reg - 1'b1);
                        if (idx_reg == cnt_n_reg - 1'b1)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_EM_RD;
                        end
                    end
                end
                S_FR_RD:
                begin
                    if (idx_reg == SLOT_CW'(SLOTS_PER_FILE))
                    begin
                        // list fully freed: drop the name
                        names_reg[ent_reg] <= '0;
                        if (req_reg == REQ_WRITE)
                        begin
                            ent_reg   <= '0;
                            state_reg <= S_EMPTY;
                        end
                        else
                        begin
                            pend_status_reg <= ST_OK;
                            pend_ent_reg    <= ent_reg;
                            state_reg       <= S_ONE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FR_CHK;
                    end
                end
                S_FR_CHK:
                begin
                    if (slot_rdata == '0)
                    begin
                        names_reg[ent_reg] <= '0;
                        if (req_reg == REQ_WRITE)
                        begin
                            ent_reg   <= '0;
                            state_reg <= S_EMPTY;
                        end
                        else
                        begin
                            pend_status_reg <= ST_OK;
                            pend_ent_reg    <= ent_reg;
                            state_reg       <= S_ONE;
                        end
                    end
                    else if (slot_in_range)
                    begin
                        sec_reg   <= slot_rdata[SECT_W-1:0];
                        state_reg <= S_FR_BM;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FR_RD;
                    end
                end
                S_FR_BM:
                begin
                    if (bm_rdata)
                    begin
                        free_reg <= free_reg + 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_FR_RD;
                end
                S_EMPTY:
                begin
                    if (names_reg[ent_reg][7:0] == 8'd0)
                    begin
                        idx_reg <= '0;
                        sec_reg <= '0;
                        if (FREE_W'(cnt_reg) > free_reg)
                        begin
                            pend_status_reg <= ST_DISK_FULL;
                            pend_ent_reg    <= '0;
                            state_reg       <= S_ONE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_reg <= S_ZERO;
                        end
                        else
                        begin
                            state_reg <= S_AL_RD;
                        end
                    end
                    else if (ent_reg == ENT_W'(DIR_ENTRIES - 1))
                    begin
                        pend_status_reg <= ST_NO_ENTRY;
                        pend_ent_reg    <= '0;
                        state_reg       <= S_ONE;
                    end
                    else
                    begin
                        ent_reg <= ent_reg + 1'b1;
                    end
                end
                S_AL_RD:
                begin
                    state_reg <= S_AL_CHK;
                end
                S_AL_CHK:
                begin
                    if (bm_rdata)
                    begin
                        sec_reg   <= sec_reg + 1'b1;
                        state_reg <= S_AL_RD;
                    end
                    else if (out_free)
                    begin
                        free_reg      <= free_reg - 1'b1;
                        status_reg    <= ST_OK;
                        entry_reg     <= 4'(ent_reg);
                        sv_reg        <= 1'b1;
                        slot_reg      <= 5'(idx_reg);
                        sector_reg    <= 8'(sec_reg);
                        last_reg      <= (idx_reg == cnt_reg - 1'b1);
                        sec_reg       <= sec_reg + 1'b1;
                        idx_reg       <= idx_reg + 1'b1;
                        state_reg     <= (idx_reg == cnt_reg - 1'b1) ? S_ZERO : S_AL_RD;
                    end
                end
                S_ZERO:
                begin
                    if (idx_reg == SLOT_CW'(SLOTS_PER_FILE))
                    begin
                        names_reg[ent_reg] <= name_reg;
                        if (cnt_reg == '0)
                        begin
                            pend_status_reg <= ST_OK;
                            pend_ent_reg    <= ent_reg;
                            state_reg       <= S_ONE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_ONE:
                begin
                    if (out_free)
                    begin
                        status_reg    <= pend_status_reg;
                        entry_reg     <= 4'(pend_ent_reg);
                        sv_reg        <= 1'b0;
                        slot_reg      <= '0;
                        sector_reg    <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_index   = entry_reg;
    assign sector_valid  = sv_reg;
    assign slot_index    = slot_reg;
    assign sector_number = sector_reg;
    assign last          = last_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(NUM_SECTORS - RESERVED_SECTORS))
        else $error("free sector count above capacity");

    a_sector_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sector_valid |-> status == ST_OK && sector_number != 8'd0)
        else $error("listed sector with bad status or zero sector");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !sector_valid && entry_index == 4'd0)
        else $error("error result not a single final word");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("request taken while busy");

endmodule
